/* hdl/dksc_pkg.sv */
package dksc_pkg;

    // Password store geometry
    localparam int PW_DEPTH = 64;
    localparam int ADDR_W   = (PW_DEPTH > 1) ? $clog2(PW_DEPTH) : 1;
    localparam int CNT_W    = $clog2(PW_DEPTH + 1);

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int PLEN_W = 7;
    localparam int SUB_W  = 3;
    localparam int KEY_W  = 3;

    // Character constants
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] THREE_DIGIT  = 8'd100;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_ENCRYPT = 2'd1,
        ACT_DECRYPT = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_KEY_EMPTY = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Key values per stored byte: two per decimal digit, bytes below 100 counting as two digits
    function automatic logic [SUB_W-1:0] values_per_byte(input logic [BYTE_W-1:0] b);
        values_per_byte = (b < THREE_DIGIT) ? 3'd4 : 3'd6;
    endfunction

    // Key value for byte b at sub-position sub.
    // Divides by 10 and 100 through reciprocal multiplies (exact for 8-bit b).
    function automatic logic [KEY_W-1:0] key_value(input logic [BYTE_W-1:0] b,
                                                   input logic [SUB_W-1:0]  sub);
        logic [15:0] p10;
        logic [15:0] p100;
        logic [4:0]  q10;
        logic [1:0]  q100;
        logic [7:0]  ones_w;
        logic [4:0]  tens_w;
        logic [3:0]  d;
        p10    = 16'(b) * 16'd205;
        p100   = 16'(b) * 16'd41;
        q10    = p10[15:11];
        q100   = p100[13:12];
        ones_w = b - 8'(q10) * 8'd10;
        tens_w = q10 - 5'(q100) * 5'd10;
        if (b < THREE_DIGIT) begin
            d = (sub[2:1] == 2'd0) ? q10[3:0] : ones_w[3:0];
        end else begin
            case (sub[2:1])
                2'd0:    d = {2'b00, q100};
                2'd1:    d = tens_w[3:0];
                default: d = ones_w[3:0];
            endcase
        end
        // even position: d/4+1, odd position: d%4+1
        key_value = sub[0] ? ({1'b0, d[1:0]} + 3'd1) : ({1'b0, d[3:2]} + 3'd1);
    endfunction

endpackage

/* hdl/dksc_ram.sv */
module dksc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (read-before-write)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/digit_keyed_shift_cipher_core.sv */
// Digit-keyed shift cipher. Password bytes are loaded with action 0 into a
// 64-entry store; data bytes are enciphered (action 1) or deciphered
// (action 2) with a repeating key derived from the decimal digits of the
// stored bytes. The core takes one transaction every clock cycle and
// returns its result in the following cycle from an output register; input
// stalls only while that register holds a result the sink has not taken.
// The byte under the key cursor is held in a register and the store's
// single read port fetches the following key byte every cycle, so a move
// to the next password byte never waits on the memory. No clearing pass
// is needed after reset: only loaded entries are ever used.
module digit_keyed_shift_cipher_core
    import dksc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [2:0]  s_tuser,   // [1:0] action, [2] restart_key
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [14:8] password_length, [15] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    // Key state
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] bc_reg, bc_next;
    logic [SUB_W-1:0]  sub_reg, sub_next;
    logic [BYTE_W-1:0] cur_byte_reg, cur_byte_next;
    logic [BYTE_W-1:0] first_byte_reg, first_byte_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    status_t           status_reg, status_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;

    // Store access
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              fwd_valid_reg;
    logic [BYTE_W-1:0] fwd_data_reg;
    logic [BYTE_W-1:0] nxt_byte;

    // Decode
    logic              accept;
    action_t           action;
    logic              restart;
    logic              full;
    logic [ADDR_W-1:0] eff_bc;
    logic [SUB_W-1:0]  eff_sub;
    logic [BYTE_W-1:0] eff_byte;
    logic [KEY_W-1:0]  key;
    logic [BYTE_W-1:0] plain;
    logic              byte_done;
    logic [CNT_W-1:0]  bc_inc;
    logic [CNT_W-1:0]  nidx_inc;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign action   = action_t'(s_tuser[1:0]);
    assign restart  = s_tuser[2];
    assign full     = (count_reg == CNT_W'(PW_DEPTH));

    // Forwarded write wins over stale read data
    assign nxt_byte = fwd_valid_reg ? fwd_data_reg : ram_rdata;

    // Key position seen by this transaction
    assign eff_bc    = restart ? '0 : bc_reg;
    assign eff_sub   = restart ? '0 : sub_reg;
    assign eff_byte  = restart ? first_byte_reg : cur_byte_reg;
    assign key       = key_value(eff_byte, eff_sub);
    assign plain     = (s_tdata == CHAR_NEWLINE) ? CHAR_SPACE : s_tdata;
    assign byte_done = (eff_sub == values_per_byte(eff_byte) - 3'd1);
    assign bc_inc    = CNT_W'(eff_bc) + CNT_W'(1);

    // Next state and result
    always_comb begin
        count_next      = count_reg;
        bc_next         = bc_reg;
        sub_next        = sub_reg;
        cur_byte_next   = cur_byte_reg;
        first_byte_next = first_byte_reg;
        m_valid_next    = m_valid_reg;
        out_byte_next   = out_byte_reg;
        status_next     = status_reg;
        plen_next       = plen_reg;
        ram_we          = 1'b0;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            m_valid_next  = 1'b1;
            out_byte_next = '0;
            status_next   = ST_OK;
            case (action)
                ACT_LOAD: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        // first password byte is also the current key byte
                        if (count_reg == '0) begin
                            cur_byte_next   = s_tdata;
                            first_byte_next = s_tdata;
                        end
                    end
                end
                ACT_ENCRYPT, ACT_DECRYPT: begin
                    bc_next  = eff_bc;
                    sub_next = eff_sub;
                    if (restart) begin
                        cur_byte_next = first_byte_reg;
                    end
                    if (count_reg == '0) begin
                        out_byte_next = s_tdata;
                        status_next   = ST_KEY_EMPTY;
                    end else begin
                        if (action == ACT_ENCRYPT) begin
                            out_byte_next = plain + BYTE_W'(key);
                        end else begin
                            out_byte_next = plain - BYTE_W'(key);
                        end
                        // advance key; restart never ends a byte (4+ values each)
                        if (byte_done) begin
                            sub_next      = '0;
                            bc_next       = (bc_inc >= count_reg) ? '0 : bc_inc[ADDR_W-1:0];
                            cur_byte_next = nxt_byte;
                        end else begin
                            sub_next = eff_sub + 3'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
            plen_next = PLEN_W'(count_next);
        end
    end

    // Prefetch the byte after the next cursor position every cycle
    assign nidx_inc  = CNT_W'(bc_next) + CNT_W'(1);
    assign ram_raddr = (nidx_inc >= count_next) ? '0 : nidx_inc[ADDR_W-1:0];

    dksc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PW_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            bc_reg        <= '0;
            sub_reg       <= '0;
            m_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            bc_reg        <= bc_next;
            sub_reg       <= sub_next;
            m_valid_reg   <= m_valid_next;
            fwd_valid_reg <= ram_we && (ram_raddr == count_reg[ADDR_W-1:0]);
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        cur_byte_reg   <= cur_byte_next;
        first_byte_reg <= first_byte_next;
        out_byte_reg   <= out_byte_next;
        status_reg     <= status_next;
        plen_reg       <= plen_next;
        fwd_data_reg   <= s_tdata;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, plen_reg, out_byte_reg};
    assign m_tuser  = status_reg;

endmodule

/* hdl/dksc_checker.sv */
module dksc_checker
    import dksc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Input stalls only behind a result that is not being taken
    a_ready_path: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output register state");

    // Every accepted transaction yields a result on the next cycle
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted transaction produced no result");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // Status code and length stay in range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3 && m_tdata[15] == 1'b0 &&
                      m_tdata[14:8] <= 7'(PW_DEPTH)))
        else $error("result status or length out of range");

endmodule

bind digit_keyed_shift_cipher_core dksc_checker u_dksc_checker (.*);
